/* rtl/core/led_fire_heat_update_defines.svh */
// assertion macros for the fire heat update block
// used by the datapath; expects signals named clock and reset in scope
`ifndef LED_FIRE_HEAT_UPDATE_DEFINES_SVH
`define LED_FIRE_HEAT_UPDATE_DEFINES_SVH

// same-cycle implication, off during reset
`define LFHU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define LFHU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/lfhu_pkg.sv */
// shared types and constants of the fire heat update block
// no dependencies; imported by every module of the block
package lfhu_pkg;

   localparam int COLUMN_W    = 4;
   localparam int ROW_W       = 4;
   localparam int HEAT_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // shared divider: 32-bit dividend, 12-bit divisor, 4 quotient bits a cycle
   localparam int DIV_N_W     = 32;
   localparam int DIV_D_W     = 12;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_CYCLES  = DIV_N_W / DIV_STEPS;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);

   localparam logic [7:0]  SPARK_RESET   = 8'd120;
   localparam logic [7:0]  COOLING_RESET = 8'd50;
   localparam logic [4:0]  ROWS_RESET    = 5'd16;
   localparam logic [31:0] SEED_RESET    = 32'd1;

   localparam int COOL_MUL    = 10;
   localparam int COOL_ADD    = 2;
   localparam int SPARK_RANGE = 255;
   localparam int SPARK_ROWS  = 7;
   localparam int SPARK_BASE  = 160;
   localparam int SPARK_SPAN  = 95;
   // floor(v/3) == (v*683)>>11 for v up to 765
   localparam int DIV3_MUL    = 683;
   localparam int DIV3_SHIFT  = 11;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPARK   = 2'd0,
      CSR_COOLING = 2'd1,
      CSR_ROWS    = 2'd2,
      CSR_SEED    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      DIV_SEL_SPAN = 3'd0,
      DIV_SEL_COOL = 3'd1,
      DIV_SEL_TEST = 3'd2,
      DIV_SEL_ROW  = 3'd3,
      DIV_SEL_AMT  = 3'd4
   } div_sel_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      div_sel_type div_sel;
      logic        row_reset;
      logic        row_inc;
      logic        rd_mem;
      logic        wr_cool;
      logic        latch_span;
      logic        latch_test;
      logic        latch_row;
      logic        latch_amt;
      logic        set_valid;
      logic        emit;
   } cmd_type;

   typedef struct packed {
      logic col_ok;
      logic div_busy;
      logic row_active;
      logic row_end_all;
      logic row_end_used;
      logic test_hit;
   } stat_type;

endpackage

/* rtl/core/lfhu_div.sv */
// iterative restoring divider, four quotient bits per cycle
// depends on lfhu_pkg for widths
module lfhu_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lfhu_pkg::DIV_N_W-1:0]  dividend,
   input  logic [lfhu_pkg::DIV_D_W-1:0]  divisor,
   output logic                          busy,
   output logic [lfhu_pkg::DIV_N_W-1:0]  quotient,
   output logic [lfhu_pkg::DIV_D_W-1:0]  remainder
);
   import lfhu_pkg::*;

   logic [DIV_N_W-1:0]   q_ff, q_in;
   logic [DIV_D_W-1:0]   r_ff, r_in;
   logic [DIV_D_W-1:0]   d_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;

   always_comb begin
      logic [DIV_D_W:0] t;
      q_in = q_ff;
      r_in = r_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         t    = {r_in, q_in[DIV_N_W-1]};
         q_in = {q_in[DIV_N_W-2:0], 1'b0};
         if (t >= {1'b0, d_ff}) begin
            r_in    = DIV_D_W'(t - {1'b0, d_ff});
            q_in[0] = 1'b1;
         end else begin
            r_in = t[DIV_D_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign busy      = busy_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

/* rtl/core/lfhu_ctrl.sv */
// sequencer of the fire heat update: cool/drift pass, spark draws, output pass
// depends on lfhu_pkg for the command and status structs
module lfhu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  lfhu_pkg::stat_type stat,
   output lfhu_pkg::cmd_type  cmd,
   output logic               busy
);
   import lfhu_pkg::*;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'h0001,
      ST_SPAN   = 14'h0002,
      ST_SPAN_W = 14'h0004,
      ST_A_RD   = 14'h0008,
      ST_A_W    = 14'h0010,
      ST_A_WR   = 14'h0020,
      ST_T      = 14'h0040,
      ST_T_W    = 14'h0080,
      ST_R      = 14'h0100,
      ST_R_W    = 14'h0200,
      ST_M      = 14'h0400,
      ST_M_W    = 14'h0800,
      ST_C_RD   = 14'h1000,
      ST_C_OUT  = 14'h2000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.div_sel = DIV_SEL_SPAN;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (stat.col_ok) state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_SPAN;
            state_in      = ST_SPAN_W;
         end
         ST_SPAN_W: begin
            if (!stat.div_busy) begin
               cmd.latch_span = 1'b1;
               cmd.row_reset  = 1'b1;
               state_in       = ST_A_RD;
            end
         end
         ST_A_RD: begin
            cmd.rd_mem = 1'b1;
            // rows above the used ones are only copied back, no draw
            if (stat.row_active) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_COOL;
            end
            state_in = ST_A_W;
         end
         ST_A_W: begin
            if (!stat.div_busy) state_in = ST_A_WR;
         end
         ST_A_WR: begin
            cmd.wr_cool = 1'b1;
            if (stat.row_end_all) begin
               cmd.set_valid = 1'b1;
               state_in      = ST_T;
            end else begin
               cmd.row_inc = 1'b1;
               state_in    = ST_A_RD;
            end
         end
         ST_T: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_TEST;
            cmd.row_reset = 1'b1;
            state_in      = ST_T_W;
         end
         ST_T_W: begin
            if (!stat.div_busy) begin
               cmd.latch_test = 1'b1;
               state_in       = stat.test_hit ? ST_R : ST_C_RD;
            end
         end
         ST_R: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_ROW;
            state_in      = ST_R_W;
         end
         ST_R_W: begin
            if (!stat.div_busy) begin
               cmd.latch_row = 1'b1;
               state_in      = ST_M;
            end
         end
         ST_M: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_AMT;
            state_in      = ST_M_W;
         end
         ST_M_W: begin
            if (!stat.div_busy) begin
               cmd.latch_amt = 1'b1;
               state_in      = ST_C_RD;
            end
         end
         ST_C_RD: begin
            cmd.rd_mem = 1'b1;
            state_in   = ST_C_OUT;
         end
         ST_C_OUT: begin
            cmd.emit = 1'b1;
            if (stat.row_end_used) begin
               state_in = ST_IDLE;
            end else begin
               cmd.row_inc = 1'b1;
               state_in    = ST_C_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* rtl/core/lfhu_dp.sv */
// datapath of the fire heat update: config registers, heat memory,
// random generator, shared divider and result registers; uses lfhu_pkg, lfhu_div
`include "led_fire_heat_update_defines.svh"

module lfhu_dp #(
   parameter int COLUMNS  = 16,
   parameter int MAX_ROWS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lfhu_pkg::cmd_type                  cmd,
   output lfhu_pkg::stat_type                 stat,
   input  logic [lfhu_pkg::COLUMN_W-1:0]      req_column,
   input  logic                               csr_we,
   input  logic [lfhu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lfhu_pkg::CSR_DATA_W-1:0]    csr_data,
   output logic                               rsp_strobe,
   output logic [lfhu_pkg::ROW_W-1:0]         rsp_row,
   output logic [lfhu_pkg::HEAT_W-1:0]        rsp_heat,
   output logic                               rsp_last
);
   import lfhu_pkg::*;

   localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int NW    = $clog2(MAX_ROWS + 1);
   localparam int DEPTH = COLUMNS * MAX_ROWS;
   localparam int AW    = $clog2(DEPTH);
   localparam int WIDE  = 8;

   function automatic logic [31:0] xorshift(input logic [31:0] x);
      logic [31:0] v;
      v = x ^ (x << 13);
      v = v ^ (v >> 17);
      v = v ^ (v << 5);
      return v;
   endfunction

   // config
   logic [7:0]  spark_chance_ff;
   logic [7:0]  cooling_ff;
   logic [4:0]  rows_cfg_ff;
   logic [31:0] rnd_ff, rnd_next;

   // per-item state
   logic [CW-1:0]      col_ff;
   logic [NW-1:0]      rows_ff, rows_in;
   logic [RW-1:0]      k_ff;
   logic [DIV_D_W-1:0] span_ff;
   logic [7:0]         c1_ff, c2_ff;
   logic               spark_ff;
   logic [2:0]         y_ff;
   logic [7:0]         add_ff;
   logic               valid_ff [COLUMNS];

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_ff;

   logic               rsp_strobe_ff, rsp_last_ff;
   logic [ROW_W-1:0]   rsp_row_ff;
   logic [HEAT_W-1:0]  rsp_heat_ff;

   logic [DIV_N_W-1:0] div_dividend, div_quot;
   logic [DIV_D_W-1:0] div_divisor, div_rem;
   logic               div_busy;

   logic [WIDE-1:0] k8, rows8, r8;
   logic [AW-1:0]   addr;
   logic [11:0]     cool_x10;
   logic [7:0]      rd_val, cooled, drift, out_heat, wr_data;
   logic [9:0]      sum3;
   logic [19:0]     prod3;
   logic [8:0]      hot;
   logic            k_ge2, spark_row, mem_we, row_active;

   lfhu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // used-row clamp
   always_comb begin
      r8 = {3'd0, rows_cfg_ff};
      if (r8 == '0) r8 = 8'd1;
      if (r8 > WIDE'(MAX_ROWS)) r8 = WIDE'(MAX_ROWS);
      rows_in = NW'(r8);
   end

   assign k8         = WIDE'(k_ff);
   assign rows8      = WIDE'(rows_ff);
   assign row_active = (k8 < rows8);
   assign addr       = AW'(col_ff) * AW'(MAX_ROWS) + AW'(k_ff);
   assign rnd_next   = xorshift(rnd_ff);
   assign cool_x10   = 12'(cooling_ff) * 12'(COOL_MUL);

   always_comb begin
      div_dividend = rnd_next;
      div_divisor  = span_ff;
      unique case (cmd.div_sel)
         DIV_SEL_SPAN: begin
            div_dividend = DIV_N_W'(cool_x10);
            div_divisor  = DIV_D_W'(rows_ff);
         end
         DIV_SEL_COOL: div_divisor = span_ff;
         DIV_SEL_TEST: div_divisor = DIV_D_W'(SPARK_RANGE);
         DIV_SEL_ROW: begin
            div_divisor = (rows8 < WIDE'(SPARK_ROWS)) ? DIV_D_W'(rows8)
                                                      : DIV_D_W'(SPARK_ROWS);
         end
         DIV_SEL_AMT: div_divisor = DIV_D_W'(SPARK_SPAN);
         default: div_divisor = span_ff;
      endcase
   end

   // a column never written reads as cold
   assign rd_val = valid_ff[col_ff] ? rd_ff : 8'd0;
   assign cooled = (div_rem > {4'd0, rd_val}) ? 8'd0 : (rd_val - div_rem[7:0]);
   assign sum3   = {2'd0, c1_ff} + {1'b0, c2_ff, 1'b0};
   assign prod3  = 20'(sum3) * 20'(DIV3_MUL);
   assign drift  = prod3[DIV3_SHIFT +: 8];
   assign k_ge2  = (k_ff > RW'(1));

   assign spark_row = spark_ff && (k8 == {5'd0, y_ff});
   assign hot       = {1'b0, rd_val} + {1'b0, add_ff};
   assign out_heat  = spark_row ? (hot[8] ? 8'hFF : hot[7:0]) : rd_val;

   always_comb begin
      if (cmd.emit) begin
         wr_data = out_heat;
      end else if (row_active) begin
         wr_data = k_ge2 ? drift : cooled;
      end else begin
         wr_data = rd_val;
      end
   end
   assign mem_we = cmd.wr_cool || (cmd.emit && spark_row);

   always_ff @(posedge clock) begin
      if (mem_we) mem[addr] <= wr_data;
      if (cmd.rd_mem) rd_ff <= mem[addr];
   end

   // config registers and random state
   always_ff @(posedge clock) begin
      if (reset) begin
         spark_chance_ff <= SPARK_RESET;
         cooling_ff      <= COOLING_RESET;
         rows_cfg_ff     <= ROWS_RESET;
         rnd_ff          <= SEED_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPARK:   spark_chance_ff <= csr_data[7:0];
            CSR_COOLING: cooling_ff      <= csr_data[7:0];
            CSR_ROWS:    rows_cfg_ff     <= csr_data[4:0];
            CSR_SEED:    rnd_ff          <= (csr_data == '0) ? SEED_RESET : csr_data;
         endcase
      end else if (cmd.div_start && (cmd.div_sel != DIV_SEL_SPAN)) begin
         rnd_ff <= rnd_next;
      end
   end

   // control state of one item
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff          <= '0;
         spark_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < COLUMNS; i++) valid_ff[i] <= 1'b0;
      end else begin
         if (cmd.load) spark_ff <= 1'b0;
         else if (cmd.latch_test) spark_ff <= stat.test_hit;
         if (cmd.row_reset) k_ff <= '0;
         else if (cmd.row_inc) k_ff <= k_ff + 1'b1;
         if (cmd.set_valid) valid_ff[col_ff] <= 1'b1;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff  <= CW'(req_column);
         rows_ff <= rows_in;
      end
      if (cmd.latch_span) span_ff <= DIV_D_W'(div_quot) + DIV_D_W'(COOL_ADD);
      if (cmd.wr_cool && row_active) begin
         c2_ff <= c1_ff;
         c1_ff <= cooled;
      end
      if (cmd.latch_row) y_ff <= div_rem[2:0];
      if (cmd.latch_amt) add_ff <= 8'(SPARK_BASE) + div_rem[7:0];
      if (cmd.emit) begin
         rsp_row_ff  <= k8[ROW_W-1:0];
         rsp_heat_ff <= out_heat;
         rsp_last_ff <= stat.row_end_used;
      end
   end

   assign stat.col_ok       = (32'(req_column) < 32'(COLUMNS));
   assign stat.div_busy     = div_busy;
   assign stat.row_active   = row_active;
   assign stat.row_end_all  = (k_ff == RW'(MAX_ROWS - 1));
   assign stat.row_end_used = ((k8 + 8'd1) == rows8);
   assign stat.test_hit     = (div_rem < {4'd0, spark_chance_ff});

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_row    = rsp_row_ff;
   assign rsp_heat   = rsp_heat_ff;
   assign rsp_last   = rsp_last_ff;

   `LFHU_ASSERT_NOW(a_emit_in_rows, cmd.emit, row_active, "result row past used rows")
   `LFHU_ASSERT_NEXT(a_strobe_gap, rsp_strobe_ff, !rsp_strobe_ff, "results back to back")
   `LFHU_ASSERT_NOW(a_div_idle, cmd.div_start, !div_busy, "divider started while busy")
   `LFHU_ASSERT_NOW(a_spark_row, spark_ff && cmd.emit, {5'd0, y_ff} < rows8, "spark row out of range")

endmodule

/* rtl/core/led_fire_heat_update.sv */
// Fire heat update, one column per command.
// Assert start with req_column while busy is low; the command is taken at that
// edge. A column at or above COLUMNS is dropped: busy stays low, no result.
// Otherwise busy rises and the column's used rows (the CSR_ROWS value, clamped to
// 1..MAX_ROWS) are cooled, drifted upward and maybe sparked, then sent out from
// the bottom row up: one word per row on rsp_row/rsp_heat/rsp_last, each valid
// for one cycle under rsp_strobe, rsp_last on the top row.
// The receiver cannot stall; results are simply taken when strobed.
// Every random draw goes through one shared divider that takes four quotient
// bits a cycle.
// Configuration: csr_we with csr_index/csr_data writes a register; the user
// must write only while busy is low, and the block itself has no guard for
// this. Writing the seed reloads the generator.
// Reset (synchronous) restores the register defaults, loads the generator with
// seed 1 and marks all columns cold through per-column valid bits, so no
// memory clearing pass is needed.
module led_fire_heat_update #(
   parameter int COLUMNS  = 16,
   parameter int MAX_ROWS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [lfhu_pkg::COLUMN_W-1:0]      req_column,
   output logic                               rsp_strobe,
   output logic [lfhu_pkg::ROW_W-1:0]         rsp_row,
   output logic [lfhu_pkg::HEAT_W-1:0]        rsp_heat,
   output logic                               rsp_last,
   input  logic                               csr_we,
   input  logic [lfhu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lfhu_pkg::CSR_DATA_W-1:0]    csr_data
);
   import lfhu_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lfhu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy)
   );

   lfhu_dp #(
      .COLUMNS  (COLUMNS),
      .MAX_ROWS (MAX_ROWS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_column (req_column),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp_row    (rsp_row),
      .rsp_heat   (rsp_heat),
      .rsp_last   (rsp_last)
   );

endmodule

/* verif/tb_led_fire_heat_update.sv */
// self-checking testbench for the fire heat update block: drives column commands and
// register writes, predicts every heat word from its own copy of the column store
// depends on lfhu_pkg and the led_fire_heat_update rtl
module tb_led_fire_heat_update;
   timeunit 1ns;
   timeprecision 1ps;
   import lfhu_pkg::*;

   localparam int COLUMNS      = 16;
   localparam int MAX_ROWS     = 16;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 51;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 300;
   localparam logic [4:0] PHASE_ROWS [PHASES] =
      '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd7, 5'd2, 5'd16};

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [HEAT_W-1:0] heat;
      logic              last;
   } heat_word_t;

   typedef struct packed {
      logic                    is_write;
      csr_index_type           index;
      logic [CSR_DATA_W-1:0]   data;
      logic [COLUMN_W-1:0]     column;
      logic                    cold;
   } plan_step_t;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [COLUMN_W-1:0]   req_column = '0;
   logic                  rsp_strobe;
   logic [ROW_W-1:0]      rsp_row;
   logic [HEAT_W-1:0]     rsp_heat;
   logic                  rsp_last;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_SPARK;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // column model
   logic [HEAT_W-1:0] cell_heat [COLUMNS][MAX_ROWS];
   logic [7:0]        spark_chance_q;
   logic [7:0]        cooling_q;
   logic [4:0]        rows_q;
   logic [31:0]       rng_q;

   heat_word_t  heat_words_due [$];
   plan_step_t  plan [$];
   int          mismatches = 0;
   int          stall_cycles = 0;

   led_fire_heat_update #(
      .COLUMNS  (COLUMNS),
      .MAX_ROWS (MAX_ROWS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_column (req_column),
      .rsp_strobe (rsp_strobe),
      .rsp_row    (rsp_row),
      .rsp_heat   (rsp_heat),
      .rsp_last   (rsp_last),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic plan_step_t reg_write_step(input csr_index_type index,
                                                  input logic [CSR_DATA_W-1:0] data);
      return '{is_write: 1'b1, index: index, data: data, column: '0, cold: 1'b0};
   endfunction

   function automatic plan_step_t column_step(input logic [COLUMN_W-1:0] column,
                                               input logic cold);
      return '{is_write: 1'b0, index: CSR_SPARK, data: '0, column: column, cold: cold};
   endfunction

   // xorshift32, one step per draw, reduced modulo the range
   function automatic int unsigned roll(input int unsigned range);
      logic [31:0] x;
      x = rng_q;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      rng_q = x;
      return (range != 0) ? x % range : 0;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // one frame of the column: cool, drift up, maybe spark; queue the words
   task automatic advance_column(input logic [COLUMN_W-1:0] col, input logic cold);
      int unsigned rows, span, cut, spot, lift;
      int unsigned h [MAX_ROWS];
      heat_word_t  w;
      rows = (rows_q == 0) ? 1 : (rows_q > MAX_ROWS) ? MAX_ROWS : rows_q;
      span = 32'(cooling_q) * COOL_MUL / rows + COOL_ADD;
      for (int k = 0; k < rows; k++) begin
         cut  = roll(span);
         h[k] = (cut > cell_heat[col][k]) ? 0 : cell_heat[col][k] - cut;
      end
      for (int k = int'(rows) - 1; k >= 2; k--)
         h[k] = (h[k-1] + 2 * h[k-2]) / 3;
      if (roll(SPARK_RANGE) < spark_chance_q) begin
         spot = roll((rows < SPARK_ROWS) ? rows : SPARK_ROWS);
         lift = SPARK_BASE + roll(SPARK_SPAN);
         h[spot] = (h[spot] + lift > 255) ? 255 : h[spot] + lift;
      end
      for (int k = 0; k < rows; k++) begin
         cell_heat[col][k] = h[k][HEAT_W-1:0];
         w.row  = k[ROW_W-1:0];
         w.heat = cold ? '0 : h[k][HEAT_W-1:0];
         w.last = (k == rows - 1);
         heat_words_due.push_back(w);
      end
   endtask

   // leaves csr_we high; the caller lowers it after the last write of a group
   task automatic write_reg(input csr_index_type index, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      @(posedge clock);
      case (index)
         CSR_SPARK:   spark_chance_q = data[7:0];
         CSR_COOLING: cooling_q = data[7:0];
         CSR_ROWS:    rows_q = data[4:0];
         CSR_SEED:    rng_q = (data == 0) ? 32'd1 : data;
         default:     ;
      endcase
   endtask

   task automatic send_column(input logic [COLUMN_W-1:0] col, input logic cold,
                              input bit steady);
      if (!steady)
         while ($urandom_range(0, 99) < 7) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start      <= 1'b1;
      req_column <= col;
      do @(posedge clock); while (busy);
      advance_column(col, cold);
   endtask

   // wait until every word is back and the block is idle
   task automatic settle();
      start <= 1'b0;
      do @(negedge clock); while (heat_words_due.size() != 0 || busy);
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      heat_word_t want;
      if (!reset && rsp_strobe) begin
         if (heat_words_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected word row %0d heat %0d last %0d",
                                    rsp_row, rsp_heat, rsp_last));
         end else begin
            want = heat_words_due.pop_front();
            if (rsp_row !== want.row)
               flag_mismatch($sformatf("row %0d, expected %0d", rsp_row, want.row));
            if (rsp_heat !== want.heat)
               flag_mismatch($sformatf("row %0d heat %0d, expected %0d",
                                       want.row, rsp_heat, want.heat));
            if (rsp_last !== want.last)
               flag_mismatch($sformatf("row %0d last %0d, expected %0d",
                                       want.row, rsp_last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_led_fire_heat_update: errors");
         $finish;
      end
   end

   initial begin
      logic [31:0] junk;
      bit          writing;
      spark_chance_q = SPARK_RESET;
      cooling_q      = COOLING_RESET;
      rows_q         = ROWS_RESET;
      rng_q          = SEED_RESET;
      foreach (cell_heat[c, r])
         cell_heat[c][r] = '0;

      // cold columns with sparks off must come back all zero
      plan.push_back(column_step(4'd3, 1'b0));
      plan.push_back(reg_write_step(CSR_SPARK, 32'hABCD_EF00));
      plan.push_back(column_step(4'd0, 1'b1));
      plan.push_back(column_step(4'd15, 1'b1));
      plan.push_back(reg_write_step(CSR_ROWS, 32'h1234_5601));
      plan.push_back(column_step(4'd1, 1'b1));
      // zero rows behaves as one row
      plan.push_back(reg_write_step(CSR_ROWS, 32'hFFFF_FFE0));
      plan.push_back(column_step(4'd2, 1'b1));
      // rows above the maximum clamp to it
      plan.push_back(reg_write_step(CSR_ROWS, 32'h0000_001F));
      plan.push_back(column_step(4'd4, 1'b1));
      // spark every frame on one row, cooling register at zero: heat saturates
      plan.push_back(reg_write_step(CSR_SPARK, 32'h0000_00FF));
      plan.push_back(reg_write_step(CSR_COOLING, 32'h5A5A_5A00));
      plan.push_back(reg_write_step(CSR_ROWS, 32'h0000_0001));
      plan.push_back(reg_write_step(CSR_SEED, 32'h0000_0000));
      repeat (4) plan.push_back(column_step(4'd5, 1'b0));
      plan.push_back(reg_write_step(CSR_COOLING, 32'h0000_00FF));
      plan.push_back(reg_write_step(CSR_ROWS, 32'h0000_0010));
      plan.push_back(reg_write_step(CSR_SEED, 32'hFFFF_FFFF));
      plan.push_back(column_step(4'd5, 1'b0));
      plan.push_back(column_step(4'd3, 1'b0));
      plan.push_back(column_step(4'd14, 1'b0));
      plan.push_back(reg_write_step(CSR_ROWS, 32'h0000_0002));
      plan.push_back(column_step(4'd6, 1'b0));
      plan.push_back(column_step(4'd6, 1'b0));
      plan.push_back(reg_write_step(CSR_ROWS, 32'h0000_0007));
      plan.push_back(column_step(4'd6, 1'b0));
      plan.push_back(column_step(4'd8, 1'b0));
      plan.push_back(reg_write_step(CSR_ROWS, 32'h0000_0008));
      plan.push_back(column_step(4'd9, 1'b0));
      plan.push_back(reg_write_step(CSR_ROWS, 32'h0000_0003));
      plan.push_back(column_step(4'd9, 1'b0));
      plan.push_back(column_step(4'd10, 1'b0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      writing = 1'b0;
      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            if (!writing)
               settle();
            write_reg(plan[i].index, plan[i].data);
            writing = 1'b1;
         end else begin
            if (writing)
               csr_we <= 1'b0;
            writing = 1'b0;
            send_column(plan[i].column, plan[i].cold, 1'b0);
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         settle();
         junk = $urandom;
         junk[7:0] = (p == 1) ? 8'd0 : (p == 2) ? 8'd255 : 8'($urandom_range(0, 255));
         write_reg(CSR_SPARK, junk);
         junk = $urandom;
         junk[7:0] = (p == 2) ? 8'd0 : (p == 5) ? 8'd255 : 8'($urandom_range(0, 255));
         write_reg(CSR_COOLING, junk);
         junk = $urandom;
         junk[4:0] = (p == 6) ? 5'($urandom_range(0, 31)) : PHASE_ROWS[p];
         write_reg(CSR_ROWS, junk);
         write_reg(CSR_SEED, (p == 3) ? 32'd0 : 32'($urandom));
         csr_we <= 1'b0;
         // phase four runs with the sender never pausing
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_column(4'($urandom_range(0, COLUMNS - 1)), 1'b0, p == 4);
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb_led_fire_heat_update: clean");
      else
         $display("tb_led_fire_heat_update: errors");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lfhu_pkg.sv
rtl/core/lfhu_div.sv
rtl/core/lfhu_ctrl.sv
rtl/core/lfhu_dp.sv
rtl/core/led_fire_heat_update.sv
verif/tb_led_fire_heat_update.sv
